/* rtl/core/utcs_pkg.sv */
// Shared types and constants for the UTF-8 text stream checker.
`timescale 1ns / 1ps
package utcs_pkg;

   // Counter numbering
   localparam int NUM_COUNTERS = 13;
   localparam int CID_W        = 4;

   localparam logic [CID_W-1:0] CNT_LINES      = 4'd0;
   localparam logic [CID_W-1:0] CNT_CRLF       = 4'd1;
   localparam logic [CID_W-1:0] CNT_TRAIL_WS   = 4'd2;
   localparam logic [CID_W-1:0] CNT_NULL       = 4'd3;
   localparam logic [CID_W-1:0] CNT_C0         = 4'd4;
   localparam logic [CID_W-1:0] CNT_C1_BYTE    = 4'd5;
   localparam logic [CID_W-1:0] CNT_HIGH_PRINT = 4'd6;
   localparam logic [CID_W-1:0] CNT_FINNISH    = 4'd7;
   localparam logic [CID_W-1:0] CNT_MISSING    = 4'd8;
   localparam logic [CID_W-1:0] CNT_ORPHAN     = 4'd9;
   localparam logic [CID_W-1:0] CNT_OVERLONG   = 4'd10;
   localparam logic [CID_W-1:0] CNT_UTF8_C1    = 4'd11;
   localparam logic [CID_W-1:0] CNT_ILLEGAL    = 4'd12;
   localparam logic [CID_W-1:0] LAST_ID        = CNT_ILLEGAL;

   // Command codes
   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_REPORT = 1'b1;

   // Decoder widths
   localparam int BE_W = 3;
   localparam int CP_W = 21;
   localparam int MV_W = 17;

   // Queue between classifier and counter bank
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                    is_report;
      logic [NUM_COUNTERS-1:0] bump;
   } queue_entry_type;

   typedef struct packed {
      logic                full;
      logic                head_valid;
      logic [QCOUNT_W-1:0] fill;
   } queue_status_type;

endpackage

/* rtl/core/utcs_if.sv */
// Handshake channel interfaces for the byte input and the counter results.
`timescale 1ns / 1ps
interface utcs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, command, data_byte, input ready);
   modport sink   (input valid, command, data_byte, output ready);
endinterface

interface utcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  counter_id;
   logic [31:0] count_value;
   logic        last_of_report;

   modport source (output valid, counter_id, count_value, last_of_report, input ready);
   modport sink   (input valid, counter_id, count_value, last_of_report, output ready);
endinterface

/* rtl/core/utf8_text_stream_checker_unit.sv */
// Top level of the UTF-8 text stream checker with text statistics.
//
// Channels: req_chan carries one transaction per byte (command 0) or a report
// request (command 1); rsp_chan carries counter results. Both use valid/ready
// and move a transaction on a rising edge with both high.
// A data byte is classified in the cycle it is accepted, queued, and added to
// the 13 saturating counters at the head of the queue; it gives no result.
// Throughput is one byte per cycle while the four-entry queue has room.
// A report gives 13 results, counter 0 first, last_of_report on counter 12.
// The first result is valid once the request reaches the head of the queue, and
// the report then holds the counter bank until its 13 results are taken, one
// result per cycle the receiver takes; bytes behind it wait in the queue.
// When the receiver stalls, the current result holds and the front end keeps
// accepting bytes until the queue fills, then drops ready.
// Synchronous reset clears the decoder state, the queue and all counters; the
// block is ready in the first cycle after reset.
`timescale 1ns / 1ps
module utf8_text_stream_checker_unit #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   utcs_req_if.sink   req_chan,
   utcs_rsp_if.source rsp_chan
);
   import utcs_pkg::*;

   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   queue_status_type q_status;
   logic             push;
   logic             pop;

   utcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   utcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   utcs_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   // Checks
   a_rsp_needs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> q_status.head_valid)
      else $error("result offered with an empty queue");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> q_status.head_valid)
      else $error("accepted transaction missing from queue");

   a_last_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_of_report) |-> rsp_chan.counter_id == LAST_ID)
      else $error("last flag on wrong counter");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.fill <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

endmodule

/* rtl/core/utcs_front.sv */
// Front end: takes bytes, runs the UTF-8 decoder and classifies each byte into counter bumps.
`timescale 1ns / 1ps
module utcs_front (
   input  logic                        clock,
   input  logic                        reset,
   utcs_req_if.sink                    req_chan,
   input  utcs_pkg::queue_status_type  q_status,
   output logic                        push,
   output utcs_pkg::queue_entry_type   push_entry
);
   import utcs_pkg::*;

   logic [BE_W-1:0] bytes_expected_ff, bytes_expected_in;
   logic [CP_W-1:0] code_point_ff, code_point_in;
   logic [MV_W-1:0] minimum_value_ff, minimum_value_in;
   logic            prev_was_cr_ff, prev_was_cr_in;
   logic            prev_was_blank_ff, prev_was_blank_in;
   logic [NUM_COUNTERS-1:0] bump;
   logic [7:0]      ch;
   logic            take_byte;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;
   assign take_byte      = push && (req_chan.command == CMD_DATA);
   assign ch             = req_chan.data_byte;

   // Decoder and byte classification
   always_comb begin
      bytes_expected_in = bytes_expected_ff;
      code_point_in     = code_point_ff;
      minimum_value_in  = minimum_value_ff;
      prev_was_cr_in    = prev_was_cr_ff;
      prev_was_blank_in = prev_was_blank_ff;
      bump              = '0;

      // broken sequence: pending bytes but no continuation
      if (bytes_expected_ff > BE_W'(1) && ch[7:6] != 2'b10) begin
         bump[CNT_MISSING] = 1'b1;
      end

      if (!ch[7]) begin
         bytes_expected_in = BE_W'(1);
      end else if (!ch[6]) begin
         if (bytes_expected_ff < BE_W'(2)) begin
            bump[CNT_ORPHAN] = 1'b1;
         end else begin
            code_point_in     = {code_point_ff[CP_W-7:0], ch[5:0]};
            bytes_expected_in = bytes_expected_ff - BE_W'(1);
            if (bytes_expected_ff == BE_W'(2)) begin
               if (code_point_in < CP_W'(minimum_value_ff)) begin
                  bump[CNT_OVERLONG] = 1'b1;
               end
               if (code_point_in >= CP_W'(8'h80) && code_point_in < CP_W'(8'ha0)) begin
                  bump[CNT_UTF8_C1] = 1'b1;
               end
            end
         end
      end else if (!ch[5]) begin
         code_point_in     = CP_W'(ch[4:0]);
         bytes_expected_in = BE_W'(2);
         minimum_value_in  = MV_W'(8'h80);
      end else if (!ch[4]) begin
         code_point_in     = CP_W'(ch[3:0]);
         bytes_expected_in = BE_W'(3);
         minimum_value_in  = MV_W'(12'h800);
      end else if (ch < 8'hf5) begin
         code_point_in     = CP_W'(ch[2:0]);
         bytes_expected_in = BE_W'(4);
         minimum_value_in  = MV_W'(17'h10000);
      end else begin
         bump[CNT_ILLEGAL] = 1'b1;
         bytes_expected_in = BE_W'(1);
      end

      // line and whitespace statistics
      if (ch == 8'h0a) begin
         bump[CNT_CRLF]     = prev_was_cr_ff;
         bump[CNT_TRAIL_WS] = prev_was_blank_ff;
         bump[CNT_LINES]    = 1'b1;
      end
      prev_was_cr_in = (ch == 8'h0d);
      if (ch != 8'h0d) begin
         prev_was_blank_in = (ch == 8'h09 || ch == 8'h20);
      end

      // raw byte classes
      bump[CNT_NULL]       = (ch == 8'h00);
      bump[CNT_C0]         = (ch inside {[8'h01:8'h1f]}) &&
                             !(ch inside {8'h09, 8'h0a, 8'h0d});
      bump[CNT_C1_BYTE]    = (ch inside {[8'h80:8'h9f]});
      bump[CNT_HIGH_PRINT] = (ch >= 8'ha0);
      bump[CNT_FINNISH]    = (ch inside {8'hc4, 8'hc5, 8'hd6, 8'he4, 8'he5, 8'hf6});
   end

   always_comb begin
      push_entry.is_report = (req_chan.command == CMD_REPORT);
      push_entry.bump      = (req_chan.command == CMD_REPORT) ? '0 : bump;
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_expected_ff <= BE_W'(1);
         code_point_ff     <= '0;
         minimum_value_ff  <= '0;
         prev_was_cr_ff    <= 1'b0;
         prev_was_blank_ff <= 1'b0;
      end else if (take_byte) begin
         bytes_expected_ff <= bytes_expected_in;
         code_point_ff     <= code_point_in;
         minimum_value_ff  <= minimum_value_in;
         prev_was_cr_ff    <= prev_was_cr_in;
         prev_was_blank_ff <= prev_was_blank_in;
      end
   end

endmodule

/* rtl/core/utcs_queue.sv */
// Short FIFO of classified transactions between front end and counter bank.
`timescale 1ns / 1ps
module utcs_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  utcs_pkg::queue_entry_type   push_entry,
   input  logic                        pop,
   output utcs_pkg::queue_entry_type   head_entry,
   output utcs_pkg::queue_status_type  q_status
);
   import utcs_pkg::*;

   queue_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign do_push = push && (fill_ff != QCOUNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && (fill_ff != '0);

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry          = entries_ff[rd_ptr_ff];
   assign q_status.full       = (fill_ff == QCOUNT_W'(QUEUE_DEPTH));
   assign q_status.head_valid = (fill_ff != '0);
   assign q_status.fill       = fill_ff;

endmodule

/* rtl/core/utcs_back.sv */
// Back end: saturating counter bank and the report sequencer.
`timescale 1ns / 1ps
module utcs_back #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  utcs_pkg::queue_entry_type   head_entry,
   input  utcs_pkg::queue_status_type  q_status,
   output logic                        pop,
   utcs_rsp_if.source                  rsp_chan
);
   import utcs_pkg::*;

   logic [COUNT_WIDTH-1:0]    cnt_ff [NUM_COUNTERS];
   logic [CID_W-1:0]          idx_ff, idx_in;
   logic                      apply_data;
   logic                      rsp_fire;
   logic [COUNT_WIDTH+31:0]   value_ext;

   assign apply_data = q_status.head_valid && !head_entry.is_report;
   assign rsp_fire   = rsp_chan.valid && rsp_chan.ready;
   assign pop        = apply_data || (rsp_fire && idx_ff == LAST_ID);

   // Report walks the counters one result per transaction
   assign rsp_chan.valid          = q_status.head_valid && head_entry.is_report;
   assign rsp_chan.counter_id     = idx_ff;
   assign value_ext               = {32'd0, cnt_ff[idx_ff]};
   assign rsp_chan.count_value    = value_ext[31:0];
   assign rsp_chan.last_of_report = (idx_ff == LAST_ID);

   always_comb begin
      idx_in = idx_ff;
      if (rsp_fire) begin
         idx_in = (idx_ff == LAST_ID) ? '0 : idx_ff + CID_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Parallel saturating increments
   for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_cnt
      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[k] <= '0;
         end else if (apply_data && head_entry.bump[k] && !(&cnt_ff[k])) begin
            cnt_ff[k] <= cnt_ff[k] + COUNT_WIDTH'(1);
         end
      end
   end

endmodule

/* tb/utcs_stats_monitor.sv */
// Checker for the UTF-8 text stream checker: predicts counter reports and compares results.
`timescale 1ns / 1ps
module utcs_stats_monitor #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   utcs_req_if  req_mon,
   utcs_rsp_if  rsp_mon,
   output int   fail_count,
   output logic drained
);
   import utcs_pkg::*;

   localparam logic [7:0] NUL   = 8'h00;
   localparam logic [7:0] TAB   = 8'h09;
   localparam logic [7:0] LF    = 8'h0a;
   localparam logic [7:0] CR    = 8'h0d;
   localparam logic [7:0] SPACE = 8'h20;

   typedef struct packed {
      logic [CID_W-1:0] id;
      logic [31:0]      value;
      logic             last;
   } counter_line_type;

   // Counter lines still owed by the block, oldest first
   counter_line_type owed_lines[$];

   // Predicted block state
   logic [COUNT_WIDTH-1:0] tally [NUM_COUNTERS];
   logic [BE_W-1:0]        need;
   logic [CP_W-1:0]        cp;
   logic [MV_W-1:0]        floor_cp;
   logic                   after_cr;
   logic                   after_blank;

   int errs = 0;
   assign fail_count = errs;

   task automatic bump(input logic [CID_W-1:0] idx);
      if (tally[idx] != '1) tally[idx] = tally[idx] + COUNT_WIDTH'(1);
   endtask

   task automatic clear_state();
      need        = BE_W'(1);
      cp          = '0;
      floor_cp    = '0;
      after_cr    = 1'b0;
      after_blank = 1'b0;
      for (int k = 0; k < NUM_COUNTERS; k++) tally[k] = '0;
   endtask

   // One data byte: UTF-8 decoder step, then the line-ending and raw-byte statistics
   task automatic tally_byte(input logic [7:0] b);
      if (need > BE_W'(1) && b[7:6] != 2'b10) bump(CNT_MISSING);

      if (!b[7]) begin
         need = BE_W'(1);
      end else if (!b[6]) begin
         if (need < BE_W'(2)) begin
            bump(CNT_ORPHAN);
         end else begin
            cp   = {cp[CP_W-7:0], b[5:0]};
            need = need - BE_W'(1);
            if (need == BE_W'(1)) begin
               if (cp < CP_W'(floor_cp)) bump(CNT_OVERLONG);
               if (cp >= 21'h80 && cp < 21'ha0) bump(CNT_UTF8_C1);
            end
         end
      end else if (!b[5]) begin
         cp       = CP_W'(b[4:0]);
         need     = BE_W'(2);
         floor_cp = 17'h80;
      end else if (!b[4]) begin
         cp       = CP_W'(b[3:0]);
         need     = BE_W'(3);
         floor_cp = 17'h800;
      end else if (b < 8'hf5) begin
         cp       = CP_W'(b[2:0]);
         need     = BE_W'(4);
         floor_cp = 17'h10000;
      end else begin
         bump(CNT_ILLEGAL);
         need = BE_W'(1);
      end

      // line endings; a CR does not disturb the blank flag
      if (b == LF) begin
         if (after_cr) bump(CNT_CRLF);
         if (after_blank) bump(CNT_TRAIL_WS);
         bump(CNT_LINES);
      end
      after_cr = (b == CR);
      if (b != CR) after_blank = (b == TAB || b == SPACE);

      if (b == NUL) bump(CNT_NULL);
      if (b != NUL && b < 8'h20 && b != CR && b != LF && b != TAB) bump(CNT_C0);
      if (b >= 8'h80 && b < 8'ha0) bump(CNT_C1_BYTE);
      if (b >= 8'ha0) bump(CNT_HIGH_PRINT);
      if (b inside {8'hc4, 8'hc5, 8'hd6, 8'he4, 8'he5, 8'hf6}) bump(CNT_FINNISH);
   endtask

   // A report owes all counters, counter 0 first
   task automatic post_report();
      counter_line_type line;
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         line.id    = CID_W'(k);
         line.value = 32'(tally[k]);
         line.last  = (CID_W'(k) == LAST_ID);
         owed_lines.push_back(line);
      end
   endtask

   always @(posedge clock) begin : watch
      counter_line_type want;
      if (reset) begin
         clear_state();
         owed_lines.delete();
      end else begin
         // result transaction against the oldest owed line
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_lines.size() == 0) begin
               $error("unexpected result: counter_id %0d, count_value %0d",
                      rsp_mon.counter_id, rsp_mon.count_value);
               errs++;
            end else begin
               want = owed_lines.pop_front();
               if (rsp_mon.counter_id !== want.id) begin
                  $error("counter_id mismatch: expected %0d, actual %0d",
                         want.id, rsp_mon.counter_id);
                  errs++;
               end
               if (rsp_mon.count_value !== want.value) begin
                  $error("count_value mismatch (counter %0d): expected %0d, actual %0d",
                         want.id, want.value, rsp_mon.count_value);
                  errs++;
               end
               if (rsp_mon.last_of_report !== want.last) begin
                  $error("last_of_report mismatch (counter %0d): expected %0d, actual %0d",
                         want.id, want.last, rsp_mon.last_of_report);
                  errs++;
               end
            end
         end
         // request transaction updates the prediction
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.command == CMD_REPORT) post_report();
            else tally_byte(req_mon.data_byte);
         end
      end
      drained <= (owed_lines.size() == 0);
   end

endmodule

/* tb/testbench.sv */
// Top of the testbench: clock, reset, byte and report stimulus, result sink and verdict.
`timescale 1ns / 1ps
module testbench;
   import utcs_pkg::*;

   localparam int HOLD_CYCLES   = 64;
   localparam int RANDOM_ITEMS  = 350;
   localparam int QUIET_TAIL    = 60;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 20;

   localparam logic [7:0] TAB   = 8'h09;
   localparam logic [7:0] LF    = 8'h0a;
   localparam logic [7:0] CR    = 8'h0d;
   localparam logic [7:0] SPACE = 8'h20;

   logic clock;
   logic reset;
   logic gaps_on     = 1'b1;
   int   holds_asked = 0;
   int   sent        = 0;
   int   stuck       = 0;
   int   fail_count;
   logic drained;

   utcs_req_if req_chan ();
   utcs_rsp_if rsp_chan ();

   utf8_text_stream_checker_unit #(.COUNT_WIDTH(32)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utcs_stats_monitor #(.COUNT_WIDTH(32)) monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .drained    (drained)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= STALL_LIMIT) begin
         $display("FAIL utf8_text_stream_checker_unit");
         $finish;
      end
   end

   // Result sink: random stall bursts, plus a long hold-off when asked
   initial begin : result_sink
      int left;
      int holds_done;
      left       = 0;
      holds_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            rsp_chan.ready <= 1'b0;
            left = HOLD_CYCLES - 1;
         end else if (left > 0) begin
            left--;
         end else if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            left = $urandom_range(0, 15);
         end else begin
            rsp_chan.ready <= 1'b1;
            left = $urandom_range(0, 23);
         end
      end
   end

   // Offer one transaction, with an occasional idle burst ahead of it
   task automatic offer(input logic cmd, input logic [7:0] b);
      int n;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 16);
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   // UTF-8 encoding of a code point at a chosen length; only the first keep bytes go out
   task automatic send_code(input logic [20:0] cp, input int len, input int keep);
      logic [7:0] enc [4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) offer(CMD_DATA, enc[i]);
   endtask

   // Stimulus
   initial begin : stimulus
      logic [7:0]  opener [26];
      logic [20:0] cp;
      int          base;
      int          r;
      int          len;
      bit          pressed;

      opener = '{8'h00, 8'h01, TAB, CR, LF, SPACE, LF,     // null, C0, blank across CR
                 8'hc2, 8'h80,                              // UTF-8 C1 code point
                 8'hc0, 8'haf,                              // overlong 2-byte
                 8'he0, 8'h80, 8'h80,                       // overlong 3-byte
                 8'he2, 8'h82, 8'hac,                       // 3-byte lead payload
                 8'hf0, 8'h9f, 8'h98, 8'h80,                // 4-byte lead payload
                 8'h80,                                     // orphan continuation
                 8'hc3, 8'h41,                              // missing continuation
                 8'hf5, 8'he4};                             // illegal lead, Finnish byte
      pressed = 1'b0;

      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_DATA;
      req_chan.data_byte = 8'h00;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed opening: report of a clean block, corner bytes, then a report
      offer(CMD_REPORT, 8'h00);
      foreach (opener[i]) offer(CMD_DATA, opener[i]);
      offer(CMD_DATA, 8'hff);
      offer(CMD_REPORT, 8'hff);

      // random part: mostly well-formed text, some broken sequences and noise
      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         if (sent - base >= RANDOM_ITEMS - QUIET_TAIL) gaps_on <= 1'b0;

         // block fills up behind a report while results are held off
         if (!pressed && sent - base >= 150) begin
            pressed = 1'b1;
            holds_asked <= holds_asked + 1;
            offer(CMD_REPORT, 8'($urandom_range(0, 255)));
            repeat (20) offer(CMD_DATA, 8'($urandom_range(8'h20, 8'h7e)));
         end

         r = $urandom_range(0, 99);
         if (r < 3) begin
            offer(CMD_REPORT, 8'($urandom_range(0, 255)));
         end else if (r < 40) begin
            case ($urandom_range(0, 9))
               0: offer(CMD_DATA, LF);
               1: begin
                  offer(CMD_DATA, CR);
                  offer(CMD_DATA, LF);
               end
               2: begin
                  offer(CMD_DATA, $urandom_range(0, 1) ? SPACE : TAB);
                  if ($urandom_range(0, 1)) offer(CMD_DATA, CR);
                  offer(CMD_DATA, LF);
               end
               3: offer(CMD_DATA, TAB);
               default: offer(CMD_DATA, 8'($urandom_range(8'h20, 8'h7e)));
            endcase
         end else if (r < 70) begin
            // well-formed multi-byte character
            len = $urandom_range(2, 4);
            case (len)
               2: cp = $urandom_range(0, 3) == 0 ? 21'($urandom_range(21'h80, 21'h9f))
                                                 : 21'($urandom_range(21'h80, 21'h7ff));
               3: cp = 21'($urandom_range(21'h800, 21'hffff));
               default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
            endcase
            send_code(cp, len, len);
         end else if (r < 76) begin
            // overlong encoding
            len = $urandom_range(2, 4);
            case (len)
               2: cp = 21'($urandom_range(0, 21'h7f));
               3: cp = 21'($urandom_range(0, 21'h7ff));
               default: cp = 21'($urandom_range(0, 21'hffff));
            endcase
            send_code(cp, len, len);
         end else if (r < 82) begin
            // truncated sequence
            len = $urandom_range(2, 4);
            send_code(21'($urandom_range(0, 21'h1fffff)), len, $urandom_range(1, len - 1));
         end else if (r < 86) begin
            offer(CMD_DATA, 8'($urandom_range(8'h80, 8'hbf)));
         end else begin
            offer(CMD_DATA, 8'($urandom_range(0, 255)));
         end
      end

      // drain: wait for every owed counter line, then let the block settle
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (!drained) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS utf8_text_stream_checker_unit");
      end else begin
         $display("FAIL utf8_text_stream_checker_unit");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/utcs_pkg.sv
rtl/core/utcs_if.sv
rtl/core/utcs_front.sv
rtl/core/utcs_queue.sv
rtl/core/utcs_back.sv
rtl/core/utf8_text_stream_checker_unit.sv
tb/utcs_stats_monitor.sv
tb/testbench.sv
